// ----- rtl/skrf_pkg.sv -----
// Shared widths, codes and word types for the scalar Kalman rate fusion block.
package skrf_pkg;

    localparam int RATE_W     = 24;              // signed Q7.16 rate
    localparam int VAR_W      = 28;              // unsigned Q12.16 variance
    localparam int CFG_IDX_W  = 2;
    localparam int MUL_W      = VAR_W + 1;       // signed operand width
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = RATE_W + VAR_W + 2;
    localparam int DEN_W      = VAR_W + 1;
    localparam int QUOT_W     = VAR_W;
    localparam int DIVIDEND_W = 2 * VAR_W;
    localparam int DIV_CNT_W  = $clog2(QUOT_W);

    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_VAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR = 2'd2;

    localparam logic CMD_IMU  = 1'b0;
    localparam logic CMD_ODOM = 1'b1;

    localparam logic [VAR_W-1:0] RESET_MEAS_VAR = 28'd32768;     // 0.5
    localparam logic [VAR_W-1:0] RESET_PROC_VAR = 28'd262144;    // 4.0
    localparam logic [VAR_W-1:0] RESET_INIT_VAR = 28'd65536000;  // 1000.0

    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
    localparam logic [VAR_W-1:0]         VAR_MAX  = {VAR_W{1'b1}};

    typedef struct packed {
        logic                     cmd;
        logic signed [RATE_W-1:0] rate_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [RATE_W-1:0] filtered_rate;
        logic [VAR_W-1:0]         estimate_variance;
    } t_out_word;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DEN_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/skrf_mul.sv -----
// Registered signed multiplier shared by the three filter products.
module skrf_mul
    import skrf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/skrf_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by both filter divisions.
module skrf_div
    import skrf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_low;     // dividend bits out, quotient bits in
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_low[QUOT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(QUOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // upper dividend half is below the divisor, so the quotient fits QUOT_W bits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.dividend[DIVIDEND_W-1:QUOT_W]};
            r_low <= i_req.dividend[QUOT_W-1:0];
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_low;

endmodule

// ----- rtl/scalar_kalman_rate_fusion.sv -----
// Scalar Kalman filter fusing IMU and odometry yaw rates, top level.
// IMU word: latched with no result; next word accepted the following cycle.
// Odometry word: result registered after 3 multiply, 1 setup, two divider passes of 28 quotient
// bits plus done, and 1 predict step; the divider passes are skipped when P + R = 0.
// No new word is taken until the odometry update is done; predict waits while the result word is stalled.
// Reset (synchronous, active low): registers to defaults, estimate zero, first-sample armed.
module scalar_kalman_rate_fusion
    import skrf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_word             i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_word            o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAR_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_A = 3'd1;
    localparam logic [2:0] S_MUL_B = 3'd2;
    localparam logic [2:0] S_MUL_C = 3'd3;
    localparam logic [2:0] S_SETUP = 3'd4;
    localparam logic [2:0] S_DIV_M = 3'd5;
    localparam logic [2:0] S_DIV_P = 3'd6;
    localparam logic [2:0] S_PRED  = 3'd7;

    localparam logic [QUOT_W-1:0] Q_POS_LIM = QUOT_W'((64'd1 << (RATE_W - 1)) - 64'd1);
    localparam logic [QUOT_W-1:0] Q_NEG_LIM = QUOT_W'(64'd1 << (RATE_W - 1));

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [VAR_W-1:0]         r_meas_var;
    logic [VAR_W-1:0]         r_proc_var;
    logic signed [RATE_W-1:0] r_mean;
    logic [VAR_W-1:0]         r_p;
    logic signed [RATE_W-1:0] r_imu;
    logic signed [RATE_W-1:0] r_prev;
    logic                     r_first;
    logic signed [RATE_W:0]   r_motion;
    logic [DEN_W-1:0]         r_den;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    t_out_word                r_out_data;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic signed [RATE_W-1:0] w_seed_mean;
    logic signed [RATE_W-1:0] w_seed_prev;
    logic                     w_mul_en;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]         w_mag;
    logic [DIVIDEND_W-1:0]    w_half_den;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;
    logic signed [RATE_W-1:0] w_q_mean;
    logic signed [RATE_W+1:0] w_sum;
    logic signed [RATE_W-1:0] w_new_mean;
    logic [VAR_W:0]           w_psum;
    logic [VAR_W-1:0]         w_new_p;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_seed_mean = r_first ? i_in_data.rate_sample : r_mean;
    assign w_seed_prev = r_first ? i_in_data.rate_sample : r_prev;

    // ---------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_data.cmd == CMD_ODOM) n_state = S_MUL_A;
            end
            S_MUL_A: n_state = S_MUL_B;
            S_MUL_B: n_state = S_MUL_C;
            S_MUL_C: n_state = S_SETUP;
            S_SETUP: n_state = (r_den == '0) ? S_PRED : S_DIV_M;
            S_DIV_M: begin
                if (w_div_rsp.done) n_state = S_DIV_P;
            end
            S_DIV_P: begin
                if (w_div_rsp.done) n_state = S_PRED;
            end
            S_PRED: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- shared multiplier: R*mean, imu*P, P*R
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = $signed({1'b0, r_p});
        w_mul_b  = $signed({1'b0, r_meas_var});
        unique case (r_state)
            S_MUL_A: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({1'b0, r_meas_var});
                w_mul_b  = MUL_W'(r_mean);
            end
            S_MUL_B: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(r_imu);
                w_mul_b  = $signed({1'b0, r_p});
            end
            S_MUL_C: begin
                w_mul_en = 1'b1;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    skrf_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // ---------------- shared divider: mean first, then variance
    assign w_mag      = r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign w_half_den = DIVIDEND_W'(r_den >> 1);

    always_comb begin
        w_div_req.start    = ((r_state == S_SETUP) && (r_den != '0))
                          || ((r_state == S_DIV_M) && w_div_rsp.done);
        w_div_req.divisor  = r_den;
        w_div_req.dividend = (r_state == S_SETUP)
                           ? DIVIDEND_W'(w_mag) + w_half_den
                           : w_prod[DIVIDEND_W-1:0] + w_half_den;
    end

    skrf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sign-magnitude quotient back to a saturated rate
    always_comb begin
        if (!r_acc[ACC_W-1]) begin
            w_q_mean = (w_div_rsp.quot > Q_POS_LIM) ? RATE_MAX
                                                    : w_div_rsp.quot[RATE_W-1:0];
        end else begin
            w_q_mean = (w_div_rsp.quot > Q_NEG_LIM) ? RATE_MIN
                                                    : -w_div_rsp.quot[RATE_W-1:0];
        end
    end

    // ---------------- prediction
    assign w_sum      = {{2{r_mean[RATE_W-1]}}, r_mean} + {r_motion[RATE_W], r_motion};
    assign w_new_mean = (w_sum[RATE_W+1:RATE_W-1] == 3'b000 ||
                         w_sum[RATE_W+1:RATE_W-1] == 3'b111)
                      ? w_sum[RATE_W-1:0]
                      : (w_sum[RATE_W+1] ? RATE_MIN : RATE_MAX);
    assign w_psum     = {1'b0, r_p} + {1'b0, r_proc_var};
    assign w_new_p    = w_psum[VAR_W] ? VAR_MAX : w_psum[VAR_W-1:0];

    // ---------------- state and filter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_meas_var  <= RESET_MEAS_VAR;
            r_proc_var  <= RESET_PROC_VAR;
            r_mean      <= '0;
            r_p         <= RESET_INIT_VAR;
            r_imu       <= '0;
            r_prev      <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // initial variance only matters before the first odometry word
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEAS_VAR: r_meas_var <= i_cfg_data;
                    CFG_PROC_VAR: r_proc_var <= i_cfg_data;
                    CFG_INIT_VAR: begin
                        if (r_first) r_p <= i_cfg_data;
                    end
                    default: ;
                endcase
            end

            if (r_state == S_PRED && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_data.cmd == CMD_IMU) begin
                            r_imu <= i_in_data.rate_sample;
                        end else begin
                            r_mean  <= w_seed_mean;
                            r_prev  <= i_in_data.rate_sample;
                            r_first <= 1'b0;
                        end
                    end
                end
                S_DIV_M: begin
                    if (w_div_rsp.done) r_mean <= w_q_mean;
                end
                S_DIV_P: begin
                    if (w_div_rsp.done) r_p <= w_div_rsp.quot;
                end
                S_PRED: begin
                    if (w_out_free) begin
                        r_mean <= w_new_mean;
                        r_p    <= w_new_p;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath words, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            r_motion <= (RATE_W + 1)'(i_in_data.rate_sample) - (RATE_W + 1)'(w_seed_prev);
            r_den    <= {1'b0, r_p} + {1'b0, r_meas_var};
        end
        if (r_state == S_MUL_B) r_acc <= w_prod[ACC_W-1:0];
        if (r_state == S_MUL_C) r_acc <= r_acc + w_prod[ACC_W-1:0];
        if (r_state == S_PRED && w_out_free) begin
            r_out_data.filtered_rate     <= w_new_mean;
            r_out_data.estimate_variance <= w_new_p;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV_M || r_state == S_DIV_P))
        else $error("divider finished outside a division step");

    a_zero_den_needs_zero_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP && r_den == '0) |-> (r_meas_var == '0))
        else $error("zero update denominator with nonzero measurement variance");

    a_odom_clears_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.cmd == CMD_ODOM) |=> (!r_first && r_state == S_MUL_A))
        else $error("odometry word did not start the update sequence");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRED && !w_out_free) |=> (r_state == S_PRED && o_out_valid))
        else $error("prediction left while result register was full");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the scalar Kalman rate fusion block: directed table, random phases.
module tb_top;
    import skrf_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int SETTLE      = 80;     // extra wait after the last expected result
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 180;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index

    typedef enum logic [1:0] {ROW_WORD, ROW_PINNED, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        t_in_word             w;
        logic [CFG_IDX_W-1:0] idx;
        logic [VAR_W-1:0]     val;
        t_out_word            want;
    } t_row;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_word             in_data  = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_word            out_data;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [VAR_W-1:0]     cfg_data  = '0;

    // filter state mirrored by the predictor
    longint          est_rate, imu_latch, prev_odom;
    longint unsigned est_var, r_meas, q_proc;
    bit              first_pending;

    t_out_word fused_q[$];   // expected results, oldest first

    int gap_pct   = 0;
    int stall_pct = 0;
    int words_sent, odom_sent, results_checked, reg_writes, mismatches;
    int unsigned cycles = 0;

    scalar_kalman_rate_fusion dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, fused_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic report_bad(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    function automatic longint clamp_rate(input longint v);
        if (v > longint'(RATE_MAX)) return longint'(RATE_MAX);
        if (v < longint'(RATE_MIN)) return longint'(RATE_MIN);
        return v;
    endfunction

    // Returns 1 when the word yields a result.
    function automatic bit fuse_step(input t_in_word w, output t_out_word r);
        longint          rate, motion, num, mag, quo;
        longint unsigned den, p;
        rate = longint'(w.rate_sample);
        r    = '0;
        if (w.cmd == CMD_IMU) begin
            imu_latch = rate;
            return 1'b0;
        end
        if (first_pending) begin
            est_rate      = rate;
            prev_odom     = rate;
            first_pending = 1'b0;
        end
        motion    = rate - prev_odom;
        prev_odom = rate;
        p   = est_var;
        den = p + r_meas;
        if (den != 0) begin
            num      = longint'(r_meas) * est_rate + imu_latch * longint'(p);
            mag      = (num < 0) ? -num : num;
            quo      = (mag + longint'(den / 2)) / longint'(den);
            est_rate = clamp_rate((num < 0) ? -quo : quo);
            p        = (p * r_meas + den / 2) / den;
        end
        est_rate = clamp_rate(est_rate + motion);
        p = p + q_proc;
        if (p > VAR_MAX) p = VAR_MAX;
        est_var = p;
        r.filtered_rate     = est_rate[RATE_W-1:0];
        r.estimate_variance = p[VAR_W-1:0];
        return 1'b1;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [VAR_W-1:0] val);
        t_row row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    function automatic t_row word_row(input logic cmd, input logic signed [RATE_W-1:0] rate);
        t_row row;
        row               = '0;
        row.kind          = ROW_WORD;
        row.w.cmd         = cmd;
        row.w.rate_sample = rate;
        return row;
    endfunction

    function automatic t_row pinned_row(input logic signed [RATE_W-1:0] rate,
                                        input logic signed [RATE_W-1:0] want_rate,
                                        input logic [VAR_W-1:0] want_var);
        t_row row;
        row                        = word_row(CMD_ODOM, rate);
        row.kind                   = ROW_PINNED;
        row.want.filtered_rate     = want_rate;
        row.want.estimate_variance = want_var;
        return row;
    endfunction

    // Called at a falling edge; returns at a falling edge after the write, with the write enable dropped.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAR_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        reg_writes++;
        case (idx)
            CFG_MEAS_VAR: r_meas = val;
            CFG_PROC_VAR: q_proc = val;
            CFG_INIT_VAR: begin
                if (first_pending) est_var = val;
            end
            default: ;
        endcase
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do @(negedge clk); while (fused_q.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input t_in_word w, input bit pinned, input t_out_word want);
        t_out_word r;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        if (fuse_step(w, r)) fused_q.push_back(pinned ? want : r);
        words_sent++;
        if (w.cmd == CMD_ODOM) odom_sent++;
        @(negedge clk);
    endtask

    always @(posedge clk) begin : check_results
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (fused_q.size() == 0) begin
                report_bad("result word with none expected", 64'(out_data), '0);
            end else begin
                want = fused_q.pop_front();
                results_checked++;
                if (out_data.filtered_rate !== want.filtered_rate)
                    report_bad("filtered_rate", 64'(out_data.filtered_rate),
                               64'(want.filtered_rate));
                if (out_data.estimate_variance !== want.estimate_variance)
                    report_bad("estimate_variance", 64'(out_data.estimate_variance),
                               64'(want.estimate_variance));
            end
        end
    end

    initial begin : stimulus
        t_row             plan[$];
        t_row             row;
        t_in_word         w;
        int               v;
        logic [VAR_W-1:0] r_val, q_val;

        r_meas        = RESET_MEAS_VAR;
        q_proc        = RESET_PROC_VAR;
        est_var       = RESET_INIT_VAR;
        est_rate      = 0;
        imu_latch     = 0;
        prev_odom     = 0;
        first_pending = 1'b1;

        // P loaded to 1 before the first sample; R = 0 makes the estimate snap to the IMU
        plan.push_back(reg_row(CFG_INIT_VAR, 28'd1));
        plan.push_back(reg_row(CFG_MEAS_VAR, 28'd0));
        plan.push_back(reg_row(CFG_PROC_VAR, 28'd0));
        plan.push_back(word_row(CMD_IMU, RATE_MAX));
        plan.push_back(pinned_row(24'sd0, RATE_MAX, 28'd0));
        // P = R = 0: update skipped, motion saturates high
        plan.push_back(pinned_row(RATE_MAX, RATE_MAX, 28'd0));
        plan.push_back(word_row(CMD_IMU, RATE_MIN));
        plan.push_back(pinned_row(RATE_MIN, RATE_MIN, 28'd0));
        plan.push_back(reg_row(CFG_PROC_VAR, VAR_MAX));
        plan.push_back(pinned_row(RATE_MIN, RATE_MIN, VAR_MAX));
        plan.push_back(pinned_row(RATE_MAX, RATE_MAX, VAR_MAX));
        plan.push_back(pinned_row(RATE_MIN, RATE_MIN, VAR_MAX));
        plan.push_back(word_row(CMD_IMU, RATE_MAX));
        plan.push_back(pinned_row(RATE_MAX, RATE_MAX, VAR_MAX));
        // R = 1 drives P to 1, so the divides land on exact halves
        plan.push_back(reg_row(CFG_MEAS_VAR, 28'd1));
        plan.push_back(reg_row(CFG_PROC_VAR, 28'd0));
        plan.push_back(word_row(CMD_ODOM, 24'sd3));
        plan.push_back(word_row(CMD_IMU, 24'sd2));
        plan.push_back(word_row(CMD_ODOM, 24'sd3));
        plan.push_back(word_row(CMD_IMU, -24'sd5));
        plan.push_back(word_row(CMD_ODOM, -24'sd2));
        plan.push_back(reg_row(CFG_MEAS_VAR, RESET_MEAS_VAR));
        plan.push_back(reg_row(CFG_PROC_VAR, RESET_PROC_VAR));
        plan.push_back(reg_row(CFG_INIT_VAR, VAR_MAX));   // too late, ignored after the first odometry word
        plan.push_back(reg_row(CFG_SPARE, VAR_MAX));
        plan.push_back(word_row(CMD_ODOM, 24'sh123456));
        plan.push_back(word_row(CMD_IMU, -24'sd1));
        plan.push_back(word_row(CMD_ODOM, -24'sh2345));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i]) begin
            row = plan[i];
            case (row.kind)
                ROW_REG: begin
                    drain(SETTLE);
                    set_reg(row.idx, row.val);
                end
                ROW_PINNED: send_word(row.w, 1'b1, row.want);
                default:    send_word(row.w, 1'b0, '0);
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain(SETTLE);
            case (ph)
                0: begin r_val = RESET_MEAS_VAR; q_val = RESET_PROC_VAR; end
                1: begin r_val = 28'd1; q_val = 28'd0; end
                2: begin r_val = VAR_MAX; q_val = VAR_MAX; end
                4: begin r_val = 28'd0; q_val = VAR_W'($urandom_range(4096)); end
                5: begin
                    r_val = VAR_W'($urandom_range(1, 256));
                    q_val = VAR_W'($urandom_range(1024));
                end
                7: begin
                    r_val = VAR_W'($urandom_range(1, 65536));
                    q_val = VAR_W'($urandom_range(65536));
                end
                default: begin
                    r_val = VAR_W'($urandom_range(1, VAR_MAX));
                    q_val = VAR_W'($urandom);
                end
            endcase
            set_reg(CFG_MEAS_VAR, r_val);
            set_reg(CFG_PROC_VAR, q_val);
            set_reg(CFG_INIT_VAR, VAR_W'($urandom_range(1, VAR_MAX)));
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 51; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 51; end
                default: begin gap_pct = 34; stall_pct <= 34; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(63) == 0) drain(0);
                w.cmd = $urandom_range(1) ? CMD_ODOM : CMD_IMU;
                case ($urandom_range(9))
                    0: w.rate_sample = $urandom_range(1) ? RATE_MAX : RATE_MIN;
                    1, 2, 3: begin
                        v = int'($urandom_range(131072)) - 65536;   // within about 1 rad/s
                        w.rate_sample = v[RATE_W-1:0];
                    end
                    default: w.rate_sample = RATE_W'($urandom);
                endcase
                send_word(w, 1'b0, '0);
            end
        end

        gap_pct = 0;
        stall_pct <= 0;
        drain(SETTLE);

        $display("Sent %0d words (%0d odometry) over %0d register settings; %0d writes.",
                 words_sent, odom_sent, PHASES + 1, reg_writes);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
